### hw/rtl/direction_to_sphere_uv_defines.svh
// Assertion macros shared by the sphere UV mapping RTL.
`ifndef DIRECTION_TO_SPHERE_UV_DEFINES_SVH
`define DIRECTION_TO_SPHERE_UV_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define DSUV_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");

// Implication with its consequence checked the next cycle.
`define DSUV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");

`endif

### hw/rtl/dsuv_pkg.sv
// Types and constants of the sphere UV mapping pipeline.
package dsuv_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_HTILE = 1'b0,
        REG_VTILE = 1'b1
    } reg_index_t;

    localparam int CORDIC_W   = 36;
    localparam int ANGLE_W    = 34;
    localparam int PROD_W     = 51;
    localparam int ROOT_BITS  = 32;
    localparam int TABLE_LEN  = 24;
    localparam logic [15:0] TILE_RESET = 16'd256;

    // atan(2^-i) in turns scaled by 2^32, rounded.
    localparam logic [31:0] TURN_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Payload carried from stage to stage; each section uses its own fields.
    typedef struct packed {
        logic signed [31:0]         xs;
        logic signed [31:0]         ys;
        logic signed [31:0]         zs;
        logic [63:0]                sqx;
        logic [63:0]                sqz;
        logic [63:0]                rad;
        logic [63:0]                root;
        logic signed [CORDIC_W-1:0] ua;
        logic signed [CORDIC_W-1:0] ub;
        logic signed [CORDIC_W-1:0] va;
        logic signed [CORDIC_W-1:0] vb;
        logic signed [ANGLE_W-1:0]  uang;
        logic signed [ANGLE_W-1:0]  vang;
        logic                       uzero;
        logic                       vzero;
        logic signed [PROD_W-1:0]   pu;
        logic signed [PROD_W-1:0]   pv;
        logic [31:0]                tex_u;
        logic [31:0]                tex_v;
    } item_t;

endpackage

### hw/rtl/direction_to_sphere_uv.sv
// Top level of the vertex to sphere texture coordinate pipeline.
//
// Usage: one vertex position enters on the s_axis channel per request and
// one result (tex_u, tex_v, signed Q16.16) leaves on the m_axis channel.
// u = htile*atan2(x,z)/(2*pi) + 0.5 and v = vtile*atan2(y,sqrt(x^2+z^2))/pi
// + 0.5, both from a vectoring CORDIC of ANGLE_STAGES stages.
// From acceptance to the result being presented, an item passes the input
// register, squaring, sum, 32 stages of a one bit per stage square root,
// pre-rotation, the CORDIC stages, tile multiply and rounding into the
// output register. One vertex per cycle unless a held result stalls the
// pipeline; every stage holds one item.
// The horizontal and vertical tile registers are written through the cfg port;
// the user must do so only while the pipeline is empty; the block does not enforce
// it. Reset sets both to 1.0 (256) and empties the pipeline. When the receiver
// holds m_tready low with a result waiting, the whole pipeline holds and s_tready
// drops; nothing is lost or repeated, and it resumes the cycle m_tready returns.
`include "direction_to_sphere_uv_defines.svh"

module direction_to_sphere_uv #(
    parameter int ANGLE_STAGES = 18,
    parameter int COORD_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // tex_u [31:0], tex_v [63:32]
);

    localparam int GUARD  = 32 - COORD_WIDTH;
    localparam int S_SQ   = 1;
    localparam int S_SUM  = 2;
    localparam int S_ROOT = 3;
    localparam int S_PRE  = S_ROOT + dsuv_pkg::ROOT_BITS;
    localparam int S_CORD = S_PRE + 1;
    localparam int S_MUL  = S_CORD + ANGLE_STAGES;
    localparam int S_OUT  = S_MUL + 1;
    localparam int DEPTH  = S_OUT + 1;

    logic [15:0] htile_reg;
    logic [15:0] vtile_reg;

    dsuv_pkg::item_t stage_reg  [DEPTH];
    dsuv_pkg::item_t stage_next [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             pipe_en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            htile_reg <= dsuv_pkg::TILE_RESET;
            vtile_reg <= dsuv_pkg::TILE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (dsuv_pkg::reg_index_t'(cfg_index))
                dsuv_pkg::REG_HTILE: htile_reg <= cfg_data;
                dsuv_pkg::REG_VTILE: vtile_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves unless a finished result is held back.
    assign pipe_en  = !valid_reg[S_OUT] || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = valid_reg[S_OUT];
    assign m_tdata  = {stage_reg[S_OUT].tex_v, stage_reg[S_OUT].tex_u};

    assign valid_next = {valid_reg[DEPTH-2:0], s_tvalid};

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Input stage: sign-extend from COORD_WIDTH bits and scale to 32 bits.
    always_comb
    begin
        stage_next[0]    = '0;
        stage_next[0].xs = signed'({16'b0, s_tdata[15:0]} << GUARD);
        stage_next[0].ys = signed'({16'b0, s_tdata[31:16]} << GUARD);
        stage_next[0].zs = signed'({16'b0, s_tdata[47:32]} << GUARD);
    end

    // Squares of the scaled horizontal coordinates.
    always_comb
    begin
        stage_next[S_SQ]     = stage_reg[S_SQ-1];
        stage_next[S_SQ].sqx = 64'(stage_reg[S_SQ-1].xs) * 64'(stage_reg[S_SQ-1].xs);
        stage_next[S_SQ].sqz = 64'(stage_reg[S_SQ-1].zs) * 64'(stage_reg[S_SQ-1].zs);
    end

    // Radicand of the horizontal radius.
    always_comb
    begin
        stage_next[S_SUM]      = stage_reg[S_SUM-1];
        stage_next[S_SUM].rad  = stage_reg[S_SUM-1].sqx + stage_reg[S_SUM-1].sqz;
        stage_next[S_SUM].root = '0;
    end

    genvar gk;
    generate
        // Square root, one result bit per stage.
        for (gk = 0; gk < dsuv_pkg::ROOT_BITS; gk++)
        begin : g_root
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gk);
            dsuv_pkg::item_t d;
            logic [63:0]     trial;
            always_comb
            begin
                d     = stage_reg[S_ROOT+gk-1];
                trial = d.root + BIT;
                if (d.rad >= trial)
                begin
                    d.rad  = d.rad - trial;
                    d.root = (d.root >> 1) + BIT;
                end
                else
                begin
                    d.root = d.root >> 1;
                end
                stage_next[S_ROOT+gk] = d;
            end
        end

        // CORDIC vectoring stages for both angles.
        for (gk = 0; gk < ANGLE_STAGES; gk++)
        begin : g_cordic
            localparam logic signed [dsuv_pkg::ANGLE_W-1:0] STEP =
                dsuv_pkg::ANGLE_W'(dsuv_pkg::TURN_TABLE[gk]);
            dsuv_pkg::item_t d;
            logic signed [dsuv_pkg::CORDIC_W-1:0] udb, uda, vdb, vda;
            always_comb
            begin
                d   = stage_reg[S_CORD+gk-1];
                udb = d.ua >>> gk;
                uda = d.ub >>> gk;
                vdb = d.va >>> gk;
                vda = d.vb >>> gk;
                if (!d.ua[dsuv_pkg::CORDIC_W-1])
                begin
                    d.ub   = d.ub + udb;
                    d.ua   = d.ua - uda;
                    d.uang = d.uang + STEP;
                end
                else
                begin
                    d.ub   = d.ub - udb;
                    d.ua   = d.ua + uda;
                    d.uang = d.uang - STEP;
                end
                if (!d.va[dsuv_pkg::CORDIC_W-1])
                begin
                    d.vb   = d.vb + vdb;
                    d.va   = d.va - vda;
                    d.vang = d.vang + STEP;
                end
                else
                begin
                    d.vb   = d.vb - vdb;
                    d.va   = d.va + vda;
                    d.vang = d.vang - STEP;
                end
                stage_next[S_CORD+gk] = d;
            end
        end
    endgenerate

    // Pre-rotation: flag zero vectors, turn vectors with negative b by half a turn.
    always_comb
    begin
        stage_next[S_PRE]       = stage_reg[S_PRE-1];
        stage_next[S_PRE].ua    = dsuv_pkg::CORDIC_W'(stage_reg[S_PRE-1].xs);
        stage_next[S_PRE].ub    = dsuv_pkg::CORDIC_W'(stage_reg[S_PRE-1].zs);
        stage_next[S_PRE].va    = dsuv_pkg::CORDIC_W'(stage_reg[S_PRE-1].ys);
        stage_next[S_PRE].vb    = signed'({4'b0, stage_reg[S_PRE-1].root[31:0]});
        stage_next[S_PRE].uang  = '0;
        stage_next[S_PRE].vang  = '0;
        stage_next[S_PRE].uzero = (stage_reg[S_PRE-1].xs == '0)
                                  && (stage_reg[S_PRE-1].zs == '0);
        stage_next[S_PRE].vzero = (stage_reg[S_PRE-1].ys == '0)
                                  && (stage_reg[S_PRE-1].root == '0);
        if (stage_reg[S_PRE-1].zs[31])
        begin
            stage_next[S_PRE].uang = stage_reg[S_PRE-1].xs[31]
                                     ? -(dsuv_pkg::ANGLE_W'(64'sd2147483648))
                                     : dsuv_pkg::ANGLE_W'(64'sd2147483648);
            stage_next[S_PRE].ua   = -stage_next[S_PRE].ua;
            stage_next[S_PRE].ub   = -stage_next[S_PRE].ub;
        end
    end

    // Scale each angle by its tile factor.
    always_comb
    begin
        stage_next[S_MUL]    = stage_reg[S_MUL-1];
        stage_next[S_MUL].pu = stage_reg[S_MUL-1].uzero ? '0
            : dsuv_pkg::PROD_W'(signed'({1'b0, htile_reg}))
              * dsuv_pkg::PROD_W'(stage_reg[S_MUL-1].uang);
        stage_next[S_MUL].pv = stage_reg[S_MUL-1].vzero ? '0
            : dsuv_pkg::PROD_W'(signed'({1'b0, vtile_reg}))
              * dsuv_pkg::PROD_W'(stage_reg[S_MUL-1].vang);
    end

    // Round to Q16.16 and add the half offset.
    always_comb
    begin
        stage_next[S_OUT]       = stage_reg[S_OUT-1];
        stage_next[S_OUT].tex_u = 32'((stage_reg[S_OUT-1].pu
                                       + dsuv_pkg::PROD_W'(64'sd8388608)) >>> 24)
                                  + 32'd32768;
        stage_next[S_OUT].tex_v = 32'((stage_reg[S_OUT-1].pv
                                       + dsuv_pkg::PROD_W'(64'sd4194304)) >>> 23)
                                  + 32'd32768;
    end

    // A held output freezes every valid bit.
    `DSUV_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(valid_reg))
    // An accepted request lands in the input stage.
    `DSUV_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, valid_reg[0])
    // The finished square root always fits in 32 bits.
    `DSUV_ASSERT_IMPL(a_root_range, valid_reg[S_PRE-1], stage_reg[S_PRE-1].root[63:32] == '0)

endmodule

### test/uv_checker.sv
// Checker for the sphere UV pipeline: predicts texture coordinates and compares results.
module uv_checker
    import dsuv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    localparam int STAGES = 18;
    localparam int GUARD  = 16;
    localparam longint HALF = 64'sd2147483648;

    logic [15:0] htile;
    logic [15:0] vtile;
    logic [63:0] expected_uv [$];

    assign pending = expected_uv.size();

    // Arithmetic shift right that rounds toward minus infinity.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // Integer square root, bit by bit.
    function automatic longint int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC angle of (b, a) in turns scaled by 2^32.
    function automatic longint vector_angle(longint b, longint a);
        longint ang;
        longint db;
        longint da;
        ang = 0;
        if (a == 0 && b == 0)
            return 0;
        if (b < 0)
        begin
            ang = (a >= 0) ? HALF : -HALF;
            b = -b;
            a = -a;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            db = floor_shr(a, i);
            da = floor_shr(b, i);
            if (a >= 0)
            begin
                b += db;
                a -= da;
                ang += longint'(TURN_TABLE[i]);
            end
            else
            begin
                b -= db;
                a += da;
                ang -= longint'(TURN_TABLE[i]);
            end
        end
        return ang;
    endfunction

    // Texture coordinates of one vertex under the current tile factors.
    function automatic logic [63:0] sphere_uv(logic [47:0] pos);
        longint x;
        longint y;
        longint z;
        longint r;
        longint au;
        longint av;
        longint u;
        longint v;
        logic [63:0] sq;
        x = longint'($signed(pos[15:0]));
        y = longint'($signed(pos[31:16]));
        z = longint'($signed(pos[47:32]));
        sq = 64'(x * x) + 64'(z * z);
        r = int_sqrt(sq << (2 * GUARD));
        au = vector_angle(z <<< GUARD, x <<< GUARD);
        av = vector_angle(r, y <<< GUARD);
        u = floor_shr(longint'(htile) * au + (64'sd1 << 23), 24) + 32768;
        v = floor_shr(longint'(vtile) * av + (64'sd1 << 22), 23) + 32768;
        return {v[31:0], u[31:0]};
    endfunction

    // Track registers, queue predictions, compare results.
    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        int          errors;
        if (!rst_n)
        begin
            htile <= TILE_RESET;
            vtile <= TILE_RESET;
            fail_count <= 0;
            expected_uv.delete();
        end
        else
        begin
            errors = 0;
            if (s_tvalid && s_tready)
                expected_uv.push_back(sphere_uv(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_uv.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_uv.pop_front();
                    if (m_tdata[31:0] !== want[31:0])
                    begin
                        $display("%0t: tex_u expected %h actual %h",
                                 $time, want[31:0], m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== want[63:32])
                    begin
                        $display("%0t: tex_v expected %h actual %h",
                                 $time, want[63:32], m_tdata[63:32]);
                        errors++;
                    end
                end
            end
            if (errors != 0)
                fail_count <= fail_count + errors;
            if (cfg_we)
            begin
                if (cfg_index == REG_HTILE)
                    htile <= cfg_data;
                else if (cfg_index == REG_VTILE)
                    vtile <= cfg_data;
            end
        end
    end

endmodule

### test/testbench.sv
// Top of the sphere UV pipeline testbench: stimulus, configuration and verdict.
module testbench;
    import dsuv_pkg::*;

    localparam int LATENCY = 60;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          calm;
    bit          stim_done;

    direction_to_sphere_uv u_dut (.*);

    uv_checker u_checker (.*);

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls in random bursts, none in the calm part.
    always @(posedge clk)
    begin
        int burst;
        if (!rst_n || calm)
            m_tready <= 1'b1;
        else if (!m_tready)
        begin
            if (burst > 0)
                burst--;
            else
                m_tready <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
    end

    // Pick a coordinate, often an extreme.
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one vertex, with an optional gap before it.
    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Wait until every result has come, then let the pipeline drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        logic [15:0] ext [4];
        logic [15:0] htiles [5];
        logic [15:0] vtiles [5];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_HTILE;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        calm = 1'b0;
        stim_done = 1'b0;
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        htiles = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'd640};
        vtiles = '{16'd256, 16'd0, 16'hFFFF, 16'd384, 16'd1};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, axes, negative z with zero x, corners.
        send_vertex(16'd0, 16'd0, 16'd0);
        send_vertex(16'd0, 16'd5, 16'd0);
        send_vertex(16'd0, 16'd0, 16'hFFF0);
        send_vertex(16'd1, 16'd0, 16'hFFF0);
        send_vertex(16'hFFFF, 16'd0, 16'hFFF0);
        send_vertex(16'd0, 16'h8000, 16'd0);
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 4; k++)
                send_vertex(ext[i], ext[(i + k) % 4], ext[k]);
        drain();

        // Random phases over several tile settings, extremes included.
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_HTILE, htiles[p]);
            write_reg(REG_VTILE, vtiles[p]);
            if (p == 4)
                calm = 1'b1;
            for (int n = 0; n < 150; n++)
                send_vertex(pick_coord(), pick_coord(), pick_coord());
            drain();
        end
        stim_done = 1'b1;
    end

    // Verdict.
    initial
    begin
        wait (stim_done);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Timeout.
    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
